### hw/rtl/text_console_putchar_unit_assert.svh
// Assertion macros for the console block.
// Each macro expects signals named clk and rst_n in scope.
`ifndef TEXT_CONSOLE_PUTCHAR_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_PUTCHAR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tcp_pkg.sv
package tcp_pkg;

    // Screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);

    // Character codes
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       char_in;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } req_t;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
    } rsp_t;

    // Screen store port request
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_SCROLL,
        ST_FINISH
    } state_t;

endpackage

### hw/rtl/tcp_screen_ram.sv
module tcp_screen_ram (
    input  logic               clk,
    input  tcp_pkg::ram_req_t  ram_req,
    output logic [7:0]         rdata
);
    import tcp_pkg::*;

    logic [7:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.addr] <= ram_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_req.re)
        begin
            rdata <= mem[ram_req.addr];
        end
    end

endmodule

### hw/rtl/text_console_putchar_unit.sv
// Text-mode teletype console, 80 columns by 25 rows, with scrolling.
// Request channel (req_valid / req_stall / req): cmd 0 puts char_in at the
// cursor (line feed and carriage return move the cursor only); cmd 1 reads
// the cell at read_row / read_col. A transfer happens when valid is high
// and stall is low.
// Response channel (rsp_valid / rsp_stall / rsp): one response per request,
// carrying the cell byte (zero on a put or an off-screen read) and the
// cursor position after the request. The response sits in an output
// register and holds while rsp_stall is high; a finished request waits in
// the last step until that register frees up.
// One request at a time. A put of a plain character, CR or LF runs an
// execute step, then a finish step that loads the response register; a
// read of an on-screen cell adds a step for the store's read data. A put
// that scrolls also blanks the bottom row, one cell per cycle, through the
// single write port of the screen store. Rows are not copied: scrolling
// rotates a top-row pointer, and the row-map adder folds it into the
// address of every put and read.
// Reset: after rst_n releases, a clearing pass writes spaces to all 2000
// cells, one per cycle; req_stall stays high until the pass is done.
module text_console_putchar_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tcp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tcp_pkg::rsp_t rsp
);
    import tcp_pkg::*;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] top_reg, top_next;         // physical row shown as row 0
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next; // clearing pass row
    logic [COL_W-1:0] clr_col_reg, clr_col_next; // clearing / scroll column
    req_t             item_reg, item_next;
    logic [7:0]       cell_reg, cell_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    ram_req_t         ram_req;
    logic [7:0]       ram_rdata;

    // Shared address unit: logical row -> physical row, then row * COLS + col
    logic [ROW_W-1:0]  log_row;
    logic [ROW_W:0]    row_sum;
    logic [ROW_W-1:0]  phys_row;
    logic              use_map;
    logic [ROW_W-1:0]  row_sel;
    logic [COL_W-1:0]  col_sel;
    logic [ADDR_W-1:0] addr_mul;

    logic             row_inc;
    logic             read_in_range;

    assign row_sum  = {1'b0, log_row} + {1'b0, top_reg};
    assign phys_row = (row_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W+1)'(ROWS))
                                                    : ROW_W'(row_sum);
    assign row_sel  = use_map ? phys_row : (state_reg == ST_CLEAR ? clr_row_reg : top_reg);
    assign addr_mul = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(COLS));

    assign read_in_range = (item_reg.read_row < ROW_W'(ROWS))
                        && (item_reg.read_col < COL_W'(COLS));

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        clr_row_next   = clr_row_reg;
        clr_col_next   = clr_col_reg;
        item_next      = item_reg;
        cell_next      = cell_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        log_row        = cur_row_reg;
        use_map        = 1'b0;
        col_sel        = clr_col_reg;
        row_inc        = 1'b0;
        ram_req.we     = 1'b0;
        ram_req.re     = 1'b0;
        ram_req.wdata  = CH_SPACE;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we = 1'b1;
                if (clr_col_reg == COL_W'(COLS - 1))
                begin
                    clr_col_next = '0;
                    if (clr_row_reg == ROW_W'(ROWS - 1))
                    begin
                        clr_row_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        clr_row_next = clr_row_reg + 1'b1;
                    end
                end
                else
                begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                use_map = 1'b1;
                if (item_reg.cmd == CMD_READ)
                begin
                    log_row = item_reg.read_row;
                    col_sel = item_reg.read_col;
                    if (read_in_range)
                    begin
                        ram_req.re = 1'b1;
                        state_next = ST_RDATA;
                    end
                    else
                    begin
                        cell_next  = '0;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    cell_next = '0;
                    col_sel   = cur_col_reg;
                    unique case (item_reg.char_in)
                        CH_LF:
                        begin
                            cur_col_next = '0;
                            row_inc      = 1'b1;
                        end
                        CH_CR:
                        begin
                            cur_col_next = '0;
                        end
                        default:
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.wdata = item_reg.char_in;
                            if (cur_col_reg == COL_W'(COLS - 1))
                            begin
                                cur_col_next = '0;
                                row_inc      = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                    endcase
                    if (row_inc && cur_row_reg == ROW_W'(ROWS - 1))
                    begin
                        clr_col_next = '0;
                        state_next   = ST_SCROLL;
                    end
                    else
                    begin
                        if (row_inc)
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_RDATA:
            begin
                cell_next  = ram_rdata;
                state_next = ST_FINISH;
            end

            ST_SCROLL:
            begin
                // old top row becomes the new blank bottom row
                ram_req.we = 1'b1;
                if (clr_col_reg == COL_W'(COLS - 1))
                begin
                    clr_col_next = '0;
                    top_next     = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
            end

            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.cell_char  = cell_reg;
                    rsp_next.cursor_col = cur_col_reg;
                    rsp_next.cursor_row = cur_row_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ram_req.addr = addr_mul + ADDR_W'(col_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            top_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            clr_row_reg   <= '0;
            clr_col_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            clr_row_reg   <= clr_row_next;
            clr_col_reg   <= clr_col_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cell_reg <= cell_next;
        rsp_reg  <= rsp_next;
    end

    tcp_screen_ram u_screen_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `include "text_console_putchar_unit_assert.svh"

    `TCP_ASSERT_NOW(a_cursor_on_grid, 1'b1,
        cur_col_reg < COL_W'(COLS) && cur_row_reg < ROW_W'(ROWS) && top_reg < ROW_W'(ROWS),
        "cursor or top-row pointer off the grid")
    `TCP_ASSERT_NOW(a_no_write_when_idle, state_reg == ST_IDLE || state_reg == ST_FINISH,
        !ram_req.we && !ram_req.re, "screen store accessed outside a working step")
    `TCP_ASSERT_NEXT(a_rsp_held_on_stall, rsp_valid && rsp_stall,
        rsp_valid && $stable(rsp), "stalled response dropped or changed")
    `TCP_ASSERT_NEXT(a_scroll_keeps_last_row, state_reg == ST_SCROLL,
        cur_row_reg == ROW_W'(ROWS - 1), "scroll left the cursor off the last row")

endmodule
